/* design/bezier_de_casteljau_evaluator_core_macros.svh */
// Assertion macros for the Bezier evaluator core
`ifndef BEZIER_DE_CASTELJAU_EVALUATOR_CORE_MACROS_SVH
`define BEZIER_DE_CASTELJAU_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdc assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define BDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdc assertion failed");

`endif

/* design/bdc_pkg.sv */
// Package: constants, types and codes of the Bezier evaluator core
`timescale 1ns / 1ps
package bdc_pkg;
    localparam int MAX_CONTROL_POINTS = 128;
    localparam int COORD_BITS         = 12;
    localparam int FRACTION_BITS      = 16;

    localparam int IDX_W    = $clog2(MAX_CONTROL_POINTS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int CURVE_W  = COORD_BITS + FRACTION_BITS;
    localparam int T_W      = FRACTION_BITS + 1;
    localparam int PROD_W   = CURVE_W + T_W;
    localparam int DIST_W   = 2 * COORD_BITS + 1;
    localparam int RAD_W    = 25;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 3;
    localparam int POINT_W  = 2 * COORD_BITS;

    localparam logic [T_W-1:0]    T_ONE      = T_W'(1) << FRACTION_BITS;
    localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(10000);

    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SELECT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EVAL    = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK           = 3'd0,
        STAT_FULL         = 3'd1,
        STAT_MISS         = 3'd2,
        STAT_NOT_DRAGGING = 3'd3,
        STAT_EMPTY        = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PASS,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               shift;
        logic               wr_en;
        logic [CURVE_W-1:0] wr_x;
        logic [CURVE_W-1:0] wr_y;
    } cell_ctl_t;
endpackage

/* design/bdc_in_if.sv */
// Interface: input item channel
`timescale 1ns / 1ps
interface bdc_in_if import bdc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [T_W-1:0]        t_param;

    modport source (output valid, mode, coord_x, coord_y, t_param, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, t_param, output ready);
endinterface

/* design/bdc_out_if.sv */
// Interface: result item channel
`timescale 1ns / 1ps
interface bdc_out_if import bdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CURVE_W-1:0] curve_x;
    logic [CURVE_W-1:0] curve_y;
    logic [IDX_W-1:0]   nearest_index;
    logic [STAT_W-1:0]  status;

    modport source (output valid, curve_x, curve_y, nearest_index, status, input ready);
    modport sink   (input valid, curve_x, curve_y, nearest_index, status, output ready);
endinterface

/* design/bezier_de_casteljau_evaluator_core.sv */
// Top level: Bezier control-point table with de Casteljau evaluation
//
// in_ch carries one command beat (mode, coord_x, coord_y, t_param); out_ch
// returns exactly one result beat per command. cfg_we/cfg_data write the
// squared search radius; the user must do so only while the block is idle,
// as the block itself does not enforce it.
// Append, move, release and unused modes, and select or evaluate on an
// empty table, finish at once: the result beat is valid the cycle after
// the command beat is taken. Select scans the point RAM one entry a cycle.
// Evaluate loads the chain of cells from the point RAM, then runs count - 1
// passes; a pass over m points streams the chain once through the shared
// interpolator. The next command beat is taken once the block is idle and
// the output register is free or being drained in the same cycle.
// A stalled receiver holds the result beat and blocks new commands.
// Reset empties the table, clears the selection and sets the radius to
// 10000; the point RAM needs no clearing.
`timescale 1ns / 1ps
`include "bezier_de_casteljau_evaluator_core_macros.svh"
module bezier_de_casteljau_evaluator_core import bdc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    bdc_in_if.sink           in_ch,
    bdc_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [RAD_W-1:0] cfg_data
);
    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      sel_reg, sel_next;
    logic                  drag_reg, drag_next;
    logic [RAD_W-1:0]      radius_reg;
    logic [CNT_W-1:0]      cyc_reg, cyc_next;
    logic [CNT_W-1:0]      m_reg, m_next;
    logic [T_W-1:0]        t_reg, t_next;
    logic [COORD_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic                  eval_reg, eval_next;
    logic [DIST_W-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]      found_reg, found_next;
    logic                  hit_reg, hit_next;
    logic                  rv_reg, rv_next;
    logic [IDX_W-1:0]      ridx_reg, ridx_next;
    logic [DIST_W-1:0]     d_reg;
    logic                  dv_reg, dv_next;
    logic [IDX_W-1:0]      didx_reg;

    logic                  ov_reg, ov_next;
    logic [CURVE_W-1:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic [IDX_W-1:0]      oidx_reg, oidx_next;
    logic [STAT_W-1:0]     ost_reg, ost_next;

    logic                  acc, done_now, load_out;
    logic                  load_end, pass_end, scan_end;
    logic                  issue;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [POINT_W-1:0]    ram_wdata, ram_rdata;
    logic [COORD_BITS-1:0] px, py, dx, dy;
    logic [DIST_W-1:0]     sq_dist;

    cell_ctl_t             ctl;
    logic [IDX_W-1:0]      wr_pos;
    logic [CURVE_W-1:0]    cx [MAX_CONTROL_POINTS];
    logic [CURVE_W-1:0]    cy [MAX_CONTROL_POINTS];

    logic                  lv;
    logic [CURVE_W-1:0]    lrx, lry;

    assign acc      = in_ch.valid && in_ch.ready;
    assign done_now = !((in_ch.mode == MODE_SELECT || in_ch.mode == MODE_EVAL) &&
                        count_reg != '0);
    assign load_out = (state_reg == ST_IDLE && acc && done_now) ||
                      (state_reg == ST_DONE && (!ov_reg || out_ch.ready));
    assign load_end = (state_reg == ST_LOAD) && (cyc_reg == count_reg);
    assign pass_end = (state_reg == ST_PASS) && (cyc_reg == m_reg);
    assign scan_end = (state_reg == ST_SCAN) && (cyc_reg == count_reg) &&
                      !rv_reg && !dv_reg;
    assign issue    = (state_reg == ST_PASS) && (cyc_reg < m_reg - 1'b1);

    assign in_ch.ready = (state_reg == ST_IDLE) && (!ov_reg || out_ch.ready);

    // point RAM: x in the upper half, y in the lower
    bdc_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_CONTROL_POINTS)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign px        = ram_rdata[POINT_W-1:COORD_BITS];
    assign py        = ram_rdata[COORD_BITS-1:0];
    assign ram_raddr = cyc_reg[IDX_W-1:0];
    assign ram_wdata = {in_ch.coord_x, in_ch.coord_y};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        if (state_reg == ST_IDLE && acc)
        begin
            if (in_ch.mode == MODE_APPEND &&
                count_reg < CNT_W'(MAX_CONTROL_POINTS))
            begin
                ram_we = 1'b1;
            end
            else if (in_ch.mode == MODE_MOVE && drag_reg &&
                     {1'b0, sel_reg} < count_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = sel_reg;
            end
        end
    end

    assign dx      = (qx_reg > px) ? qx_reg - px : px - qx_reg;
    assign dy      = (qy_reg > py) ? qy_reg - py : py - qy_reg;
    assign sq_dist = DIST_W'(dx * dx) + DIST_W'(dy * dy);

    // chain of cells, head at index 0
    always_comb
    begin
        ctl.shift = (state_reg == ST_LOAD) || (state_reg == ST_PASS);
        if (state_reg == ST_LOAD)
        begin
            ctl.wr_en = rv_reg;
            ctl.wr_x  = {px, FRACTION_BITS'(0)};
            ctl.wr_y  = {py, FRACTION_BITS'(0)};
            wr_pos    = IDX_W'(count_reg - 1'b1);
        end
        else
        begin
            ctl.wr_en = lv;
            ctl.wr_x  = lrx;
            ctl.wr_y  = lry;
            wr_pos    = IDX_W'(m_reg - 2'd2);
        end
    end

    for (genvar i = 0; i < MAX_CONTROL_POINTS; i++)
    begin : g_cell
        logic [CURVE_W-1:0] nb_x, nb_y;
        if (i == MAX_CONTROL_POINTS - 1)
        begin : g_tail
            assign nb_x = '0;
            assign nb_y = '0;
        end
        else
        begin : g_mid
            assign nb_x = cx[i+1];
            assign nb_y = cy[i+1];
        end
        bdc_cell u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .wr_sel (wr_pos == IDX_W'(i)),
            .nb_x   (nb_x),
            .nb_y   (nb_y),
            .x      (cx[i]),
            .y      (cy[i])
        );
    end

    bdc_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (issue),
        .t         (t_reg),
        .ax        (cx[0]),
        .bx        (cx[1]),
        .ay        (cy[0]),
        .by        (cy[1]),
        .res_valid (lv),
        .rx        (lrx),
        .ry        (lry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && in_ch.mode == MODE_SELECT && count_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
                else if (acc && in_ch.mode == MODE_EVAL && count_reg != '0)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (load_end)
                begin
                    state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (pass_end && m_reg == CNT_W'(2))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next = count_reg;
        sel_next   = sel_reg;
        drag_next  = drag_reg;
        cyc_next   = cyc_reg;
        m_next     = m_reg;
        t_next     = t_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        eval_next  = eval_reg;
        best_next  = best_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        rv_next    = 1'b0;
        ridx_next  = cyc_reg[IDX_W-1:0];
        dv_next    = rv_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oidx_next  = oidx_reg;
        ost_next   = ost_reg;
        ov_next    = ov_reg && !out_ch.ready;
        if (load_out)
        begin
            ov_next   = 1'b1;
            ox_next   = '0;
            oy_next   = '0;
            oidx_next = '0;
            ost_next  = STAT_OK;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cyc_next  = '0;
                qx_next   = in_ch.coord_x;
                qy_next   = in_ch.coord_y;
                t_next    = (in_ch.t_param > T_ONE) ? T_ONE : in_ch.t_param;
                m_next    = count_reg;
                best_next = DIST_W'(radius_reg);
                hit_next  = 1'b0;
                eval_next = (in_ch.mode == MODE_EVAL);
                if (acc)
                begin
                    unique case (in_ch.mode)
                        MODE_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_CONTROL_POINTS))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ost_next = STAT_FULL;
                            end
                        end
                        MODE_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                sel_next  = '0;
                                drag_next = 1'b0;
                                ost_next  = STAT_MISS;
                            end
                        end
                        MODE_MOVE:
                        begin
                            if (!(drag_reg && {1'b0, sel_reg} < count_reg))
                            begin
                                ost_next = STAT_NOT_DRAGGING;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            sel_next  = '0;
                            drag_next = 1'b0;
                        end
                        MODE_EVAL:
                        begin
                            if (count_reg == '0)
                            begin
                                ost_next = STAT_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                rv_next  = (cyc_reg < count_reg);
                cyc_next = load_end ? '0 : cyc_reg + 1'b1;
            end
            ST_PASS:
            begin
                cyc_next = pass_end ? '0 : cyc_reg + 1'b1;
                if (pass_end)
                begin
                    m_next = m_reg - 1'b1;
                end
            end
            ST_SCAN:
            begin
                rv_next = (cyc_reg < count_reg);
                if (cyc_reg < count_reg)
                begin
                    cyc_next = cyc_reg + 1'b1;
                end
                if (dv_reg && d_reg < best_reg)
                begin
                    best_next  = d_reg;
                    found_next = didx_reg;
                    hit_next   = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    if (eval_reg)
                    begin
                        ox_next = cx[0];
                        oy_next = cy[0];
                    end
                    else if (hit_reg)
                    begin
                        sel_next  = found_reg;
                        drag_next = 1'b1;
                        oidx_next = found_reg;
                    end
                    else
                    begin
                        sel_next  = '0;
                        drag_next = 1'b0;
                        ost_next  = STAT_MISS;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            sel_reg    <= '0;
            drag_reg   <= 1'b0;
            radius_reg <= RADIUS_RST;
            cyc_reg    <= '0;
            rv_reg     <= 1'b0;
            dv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            eval_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sel_reg   <= sel_next;
            drag_reg  <= drag_next;
            cyc_reg   <= cyc_next;
            rv_reg    <= rv_next;
            dv_reg    <= dv_next;
            ov_reg    <= ov_next;
            hit_reg   <= hit_next;
            eval_reg  <= eval_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        t_reg     <= t_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        ridx_reg  <= ridx_next;
        d_reg     <= sq_dist;
        didx_reg  <= ridx_reg;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oidx_reg  <= oidx_next;
        ost_reg   <= ost_next;
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.curve_x       = ox_reg;
    assign out_ch.curve_y       = oy_reg;
    assign out_ch.nearest_index = oidx_reg;
    assign out_ch.status        = ost_reg;

    `BDC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_CONTROL_POINTS))
    `BDC_ASSERT_NOW(a_lerp_in_pass, lv, state_reg == ST_PASS)
    `BDC_ASSERT_NOW(a_drag_valid, drag_reg, {1'b0, sel_reg} < count_reg)
    `BDC_ASSERT_NEXT(a_done_beat, state_reg == ST_DONE && load_out, ov_reg)
endmodule

/* design/bdc_ram.sv */
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module bdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* design/bdc_cell.sv */
// Cell of the working-point chain: holds one point, shifts toward the head
`timescale 1ns / 1ps
module bdc_cell import bdc_pkg::*; (
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic               wr_sel,
    input  logic [CURVE_W-1:0] nb_x,
    input  logic [CURVE_W-1:0] nb_y,
    output logic [CURVE_W-1:0] x,
    output logic [CURVE_W-1:0] y
);
    logic [CURVE_W-1:0] x_reg, x_next;
    logic [CURVE_W-1:0] y_reg, y_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctl.wr_en && wr_sel)
        begin
            x_next = ctl.wr_x;
            y_next = ctl.wr_y;
        end
        else if (ctl.shift)
        begin
            x_next = nb_x;
            y_next = nb_y;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x = x_reg;
    assign y = y_reg;
endmodule

/* design/bdc_lerp.sv */
// Shared two-stage fixed-point interpolator for x and y
`timescale 1ns / 1ps
module bdc_lerp import bdc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  logic [T_W-1:0]     t,
    input  logic [CURVE_W-1:0] ax,
    input  logic [CURVE_W-1:0] bx,
    input  logic [CURVE_W-1:0] ay,
    input  logic [CURVE_W-1:0] by,
    output logic               res_valid,
    output logic [CURVE_W-1:0] rx,
    output logic [CURVE_W-1:0] ry
);
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(T_ONE >> 1);

    logic [T_W-1:0]     omt;
    logic [PROD_W-1:0]  pax_reg, pbx_reg, pay_reg, pby_reg;
    logic [PROD_W:0]    sum_x, sum_y;
    logic               v1_reg, v2_reg;
    logic [CURVE_W-1:0] rx_reg, ry_reg;

    assign omt = T_ONE - t;

    always_ff @(posedge clk)
    begin
        pax_reg <= PROD_W'(omt) * PROD_W'(ax);
        pbx_reg <= PROD_W'(t) * PROD_W'(bx);
        pay_reg <= PROD_W'(omt) * PROD_W'(ay);
        pby_reg <= PROD_W'(t) * PROD_W'(by);
        rx_reg  <= sum_x[FRACTION_BITS +: CURVE_W];
        ry_reg  <= sum_y[FRACTION_BITS +: CURVE_W];
    end

    assign sum_x = {1'b0, pax_reg} + {1'b0, pbx_reg} + HALF;
    assign sum_y = {1'b0, pay_reg} + {1'b0, pby_reg} + HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
        end
    end

    assign res_valid = v2_reg;
    assign rx        = rx_reg;
    assign ry        = ry_reg;
endmodule
